/* sv/vsc_pkg.sv */
// Shared types, constants and helpers for the version string compare block.
// No dependencies; imported by vsc_front, vsc_back and the top level.
package vsc_pkg;

    localparam int MAX_LEN = 64;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
    localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
    localparam logic [1:0] OP_COMPARE       = 2'd2;

    localparam logic signed [1:0] ORD_EQ = 2'sb00;
    localparam logic signed [1:0] ORD_GT = 2'sb01;
    localparam logic signed [1:0] ORD_LT = 2'sb11;

    typedef enum logic [1:0] {
        CMD_APPEND_FIRST,
        CMD_APPEND_SECOND,
        CMD_COMPARE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] ch;
    } vsc_cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RUN,
        BK_ZERO,
        BK_DIGIT,
        BK_TEXT
    } back_state_t;

    function automatic logic is_num(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

/* sv/vsc_front.sv */
// Front end: accepts commands, classifies the opcode and queues the command.
// Depends on vsc_pkg.
module vsc_front
    import vsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] opcode,
    input  logic [7:0] char_byte,
    output logic       busy,
    output logic       q_valid,
    output vsc_cmd_t   q_cmd,
    input  logic       q_pop
);

    vsc_cmd_t           q_mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push;
    logic               known_op;
    cmd_kind_t          kind;

    // Classify; the unused opcode is dropped here.
    always_comb
    begin
        known_op = 1'b1;
        kind     = CMD_COMPARE;
        unique case (opcode)
            OP_APPEND_FIRST:  kind = CMD_APPEND_FIRST;
            OP_APPEND_SECOND: kind = CMD_APPEND_SECOND;
            OP_COMPARE:       kind = CMD_COMPARE;
            default:          known_op = 1'b0;
        endcase
    end

    assign busy    = (count_reg == QCNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = q_mem[rd_ptr_reg];
    assign push    = start && !busy && known_op;

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{kind: kind, ch: char_byte};
        end
    end

endmodule

/* sv/vsc_back.sv */
// Back end: stores appended bytes and walks both strings run by run on compare.
// Depends on vsc_pkg; fed by the command queue in vsc_front.
module vsc_back
    import vsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  vsc_cmd_t          q_cmd,
    output logic              q_pop,
    output logic              done,
    output logic signed [1:0] order,
    output logic              truncated
);

    logic [7:0]        first_mem  [MAX_LEN];
    logic [7:0]        second_mem [MAX_LEN];

    back_state_t       state_reg, state_next;
    logic [LEN_W-1:0]  cnt_a_reg, cnt_a_next;
    logic [LEN_W-1:0]  cnt_b_reg, cnt_b_next;
    logic [LEN_W-1:0]  ia_reg, ia_next;
    logic [LEN_W-1:0]  jb_reg, jb_next;
    logic              ovf_reg, ovf_next;
    logic signed [1:0] tie_reg, tie_next;
    logic [7:0]        a_byte_reg, b_byte_reg;
    logic              done_reg;
    logic signed [1:0] order_reg;
    logic              trunc_reg;

    logic              a_in, b_in, a_dig, b_dig, a_zero, b_zero;
    logic              a_run_d, b_run_d, a_run_t, b_run_t;
    logic              bytes_differ;
    logic signed [1:0] byte_ord;
    logic              fin;
    logic signed [1:0] fin_ord;
    logic              adv_a, adv_b, wr_a, wr_b, ovf_set, is_cmp;

    assign a_in         = (ia_reg < cnt_a_reg);
    assign b_in         = (jb_reg < cnt_b_reg);
    assign a_dig        = is_num(a_byte_reg);
    assign b_dig        = is_num(b_byte_reg);
    assign a_zero       = a_in && (a_byte_reg == CH_ZERO);
    assign b_zero       = b_in && (b_byte_reg == CH_ZERO);
    assign a_run_d      = a_in && a_dig;
    assign b_run_d      = b_in && b_dig;
    assign a_run_t      = a_in && !a_dig;
    assign b_run_t      = b_in && !b_dig;
    assign bytes_differ = (a_byte_reg != b_byte_reg);
    assign byte_ord     = (a_byte_reg > b_byte_reg) ? ORD_GT : ORD_LT;
    assign is_cmp       = q_valid && (q_cmd.kind == CMD_COMPARE);

    // Per-state decisions shared by the next-state and datapath logic
    always_comb
    begin
        fin      = 1'b0;
        fin_ord  = ORD_EQ;
        adv_a    = 1'b0;
        adv_b    = 1'b0;
        wr_a     = 1'b0;
        wr_b     = 1'b0;
        ovf_set  = 1'b0;
        q_pop    = 1'b0;
        tie_next = tie_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        CMD_APPEND_FIRST:
                        begin
                            wr_a    = (cnt_a_reg < LEN_W'(MAX_LEN));
                            ovf_set = !wr_a;
                        end
                        CMD_APPEND_SECOND:
                        begin
                            wr_b    = (cnt_b_reg < LEN_W'(MAX_LEN));
                            ovf_set = !wr_b;
                        end
                        default:
                        begin
                            tie_next = ORD_EQ;
                        end
                    endcase
                end
            end
            BK_RUN:
            begin
                tie_next = ORD_EQ;
                if (!(a_in && b_in))
                begin
                    fin     = 1'b1;
                    fin_ord = (!a_in && !b_in) ? ORD_EQ : (a_in ? ORD_GT : ORD_LT);
                end
                else if (a_dig != b_dig)
                begin
                    // second run is empty: digit side sorts greater
                    fin     = 1'b1;
                    fin_ord = a_dig ? ORD_GT : ORD_LT;
                end
            end
            BK_ZERO:
            begin
                adv_a = a_zero;
                adv_b = b_zero;
            end
            BK_DIGIT:
            begin
                if (a_run_d && b_run_d)
                begin
                    adv_a = 1'b1;
                    adv_b = 1'b1;
                    if (tie_reg == ORD_EQ && bytes_differ)
                    begin
                        tie_next = byte_ord;
                    end
                end
                else if (a_run_d)
                begin
                    fin     = 1'b1;
                    fin_ord = ORD_GT;
                end
                else if (b_run_d)
                begin
                    fin     = 1'b1;
                    fin_ord = ORD_LT;
                end
                else if (tie_reg != ORD_EQ)
                begin
                    fin     = 1'b1;
                    fin_ord = tie_reg;
                end
            end
            BK_TEXT:
            begin
                if (a_run_t && b_run_t)
                begin
                    if (bytes_differ)
                    begin
                        fin     = 1'b1;
                        fin_ord = byte_ord;
                    end
                    else
                    begin
                        adv_a = 1'b1;
                        adv_b = 1'b1;
                    end
                end
                else if (a_run_t)
                begin
                    fin     = 1'b1;
                    fin_ord = ORD_GT;
                end
                else if (b_run_t)
                begin
                    fin     = 1'b1;
                    fin_ord = ORD_LT;
                end
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (is_cmp)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (fin)
                begin
                    state_next = BK_IDLE;
                end
                else
                begin
                    state_next = a_dig ? BK_ZERO : BK_TEXT;
                end
            end
            BK_ZERO:
            begin
                if (!a_zero && !b_zero)
                begin
                    state_next = BK_DIGIT;
                end
            end
            BK_DIGIT:
            begin
                if (fin)
                begin
                    state_next = BK_IDLE;
                end
                else if (!a_run_d && !b_run_d)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_TEXT:
            begin
                if (fin)
                begin
                    state_next = BK_IDLE;
                end
                else if (!a_run_t && !b_run_t)
                begin
                    state_next = BK_RUN;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ia_next    = (state_reg == BK_IDLE) ? '0 : ia_reg + LEN_W'(adv_a);
        jb_next    = (state_reg == BK_IDLE) ? '0 : jb_reg + LEN_W'(adv_b);
        cnt_a_next = fin ? '0 : cnt_a_reg + LEN_W'(wr_a);
        cnt_b_next = fin ? '0 : cnt_b_reg + LEN_W'(wr_b);
        ovf_next   = fin ? 1'b0 : (ovf_reg || ovf_set);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            ia_reg    <= '0;
            jb_reg    <= '0;
            ovf_reg   <= 1'b0;
            tie_reg   <= ORD_EQ;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            ia_reg    <= ia_next;
            jb_reg    <= jb_next;
            ovf_reg   <= ovf_next;
            tie_reg   <= tie_next;
            done_reg  <= fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            order_reg <= fin_ord;
            trunc_reg <= ovf_reg;
        end
    end

    // Read data is registered from the next walk index, so it matches the walk index register
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            first_mem[cnt_a_reg[ADDR_W-1:0]] <= q_cmd.ch;
        end
        a_byte_reg <= first_mem[ia_next[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            second_mem[cnt_b_reg[ADDR_W-1:0]] <= q_cmd.ch;
        end
        b_byte_reg <= second_mem[jb_next[ADDR_W-1:0]];
    end

    assign done      = done_reg;
    assign order     = order_reg;
    assign truncated = trunc_reg;

endmodule

/* sv/version_string_compare_top.sv */
// Channel   | Signals                      | Handshake
// ----------+------------------------------+--------------------------------
// command   | opcode, char_byte            | transfer when start && !busy
// result    | order, truncated             | one-cycle strobe on done
//
// The back end stores each append without leaving its idle state. A compare
// walks the stored bytes run by run through the run, zero, digit and text
// states; each string memory has a single read port. A four-entry command
// queue sits between front and back; busy rises only when it is full. Reset
// clears counts, queue and state; string contents are not cleared. Results
// cannot be stalled.
// Depends on vsc_pkg, vsc_front and vsc_back.
module version_string_compare_top
    import vsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        opcode,
    input  logic [7:0]        char_byte,
    output logic              done,
    output logic signed [1:0] order,
    output logic              truncated
);

    logic     q_valid;
    logic     q_pop;
    vsc_cmd_t q_cmd;

    vsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .opcode    (opcode),
        .char_byte (char_byte),
        .busy      (busy),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop)
    );

    vsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .done      (done),
        .order     (order),
        .truncated (truncated)
    );

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("command queue popped while empty");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results on consecutive cycles");

    a_order_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (order != 2'b10))
        else $error("illegal order code");
`endif

endmodule

/* test/tb.sv */
// Self-checking testbench for version_string_compare_top: loads string pairs,
// checks every ordering result against a predictor kept inside this file or against the values typed into the script.
// Depends on vsc_pkg and the version_string_compare_top RTL.
module tb;
    import vsc_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         ITEM_TARGET = 1000;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         SETTLE      = 600;

    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        ch;
        bit                typed;
        logic signed [1:0] ord;
        bit                trunc;
    } step_t;

    typedef struct packed {
        logic signed [1:0] ord;
        bit                trunc;
    } verdict_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        opcode;
    logic [7:0]        char_byte;
    logic              done;
    logic signed [1:0] order;
    logic              truncated;

    // predictor state
    logic [7:0] lhs_bytes [MAX_LEN];
    logic [7:0] rhs_bytes [MAX_LEN];
    int         lhs_len;
    int         rhs_len;
    bit         dropped;

    verdict_t   pending_verdicts [$];
    logic [7:0] lhs_src [$];
    logic [7:0] rhs_src [$];
    logic [7:0] scratch [$];
    step_t      script [0:23];

    int errors      = 0;
    int cycle_count = 0;
    int n_sent      = 0;
    bit calm        = 1'b0;

    version_string_compare_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .char_byte (char_byte),
        .done      (done),
        .order     (order),
        .truncated (truncated)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still pending", $time,
                     pending_verdicts.size());
            $display("tb: errors");
            $finish;
        end
    end

    function automatic bit digit_char(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Walk both strings in runs; the run kind follows the first string.
    function automatic logic signed [1:0] rank_versions();
        int  lo_a;
        int  lo_b;
        int  end_a;
        int  end_b;
        bit  dig;
        end_a = 0;
        end_b = 0;
        while (end_a < lhs_len && end_b < rhs_len)
        begin
            lo_a = end_a;
            lo_b = end_b;
            dig  = digit_char(lhs_bytes[end_a]);
            while (end_a < lhs_len && digit_char(lhs_bytes[end_a]) == dig)
                end_a++;
            while (end_b < rhs_len && digit_char(rhs_bytes[end_b]) == dig)
                end_b++;
            if (lo_b == end_b)
                return dig ? ORD_GT : ORD_LT;
            if (dig)
            begin
                while (lo_a < end_a && lhs_bytes[lo_a] == CH_ZERO)
                    lo_a++;
                while (lo_b < end_b && rhs_bytes[lo_b] == CH_ZERO)
                    lo_b++;
                if (end_a - lo_a > end_b - lo_b)
                    return ORD_GT;
                if (end_a - lo_a < end_b - lo_b)
                    return ORD_LT;
            end
            while (lo_a < end_a && lo_b < end_b)
            begin
                if (lhs_bytes[lo_a] != rhs_bytes[lo_b])
                    return (lhs_bytes[lo_a] > rhs_bytes[lo_b]) ? ORD_GT : ORD_LT;
                lo_a++;
                lo_b++;
            end
            if (lo_a < end_a)
                return ORD_GT;
            if (lo_b < end_b)
                return ORD_LT;
        end
        if (end_a >= lhs_len && end_b >= rhs_len)
            return ORD_EQ;
        return (end_a < lhs_len) ? ORD_GT : ORD_LT;
    endfunction

    // Advance the predictor by one accepted transfer.
    function automatic void absorb(input logic [1:0] op, input logic [7:0] ch,
                                   input bit typed, input logic signed [1:0] t_ord,
                                   input bit t_trunc);
        verdict_t v;
        case (op)
            OP_APPEND_FIRST:
                if (lhs_len < MAX_LEN)
                    lhs_bytes[lhs_len++] = ch;
                else
                    dropped = 1'b1;
            OP_APPEND_SECOND:
                if (rhs_len < MAX_LEN)
                    rhs_bytes[rhs_len++] = ch;
                else
                    dropped = 1'b1;
            OP_COMPARE:
            begin
                v.ord   = typed ? t_ord : rank_versions();
                v.trunc = typed ? t_trunc : dropped;
                pending_verdicts.push_back(v);
                lhs_len = 0;
                rhs_len = 0;
                dropped = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] pick_char(input bit want_digit);
        logic [7:0] c;
        if (want_digit)
            return CH_ZERO + 8'($urandom_range(0, 9));
        case ($urandom_range(0, 3))
            0: c = 8'h2E;
            1: c = 8'h61 + 8'($urandom_range(0, 25));
            2: c = $urandom_range(0, 1) ? 8'h2F : 8'h3A;
            default:
            begin
                c = 8'($urandom_range(0, 255));
                while (digit_char(c))
                    c = 8'($urandom_range(0, 255));
            end
        endcase
        return c;
    endfunction

    // Build a string of alternating digit and text runs, with some noise.
    function automatic void make_text(input int len);
        bit dig;
        int run;
        scratch.delete();
        dig = 1'($urandom_range(0, 1));
        run = 0;
        for (int i = 0; i < len; i++)
        begin
            if (run == 0)
            begin
                run = $urandom_range(1, 4);
                dig = !dig;
            end
            if ($urandom_range(0, 19) == 0)
                scratch.push_back(8'($urandom_range(0, 255)));
            else if (dig && $urandom_range(0, 3) == 0)
                scratch.push_back(CH_ZERO);
            else
                scratch.push_back(pick_char(dig));
            run--;
        end
    endfunction

    task automatic send_cmd(input logic [1:0] op, input logic [7:0] ch,
                            input bit typed = 1'b0,
                            input logic signed [1:0] t_ord = ORD_EQ,
                            input bit t_trunc = 1'b0);
        start     <= 1'b1;
        opcode    <= op;
        char_byte <= ch;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        absorb(op, ch, typed, t_ord, t_trunc);
        if (op != OP_UNUSED)
            n_sent++;
        if (!calm && $urandom_range(0, 99) < 12)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
    endtask

    // Hold off until every pending result has come back.
    task automatic drain();
        if (start)
            start <= 1'b0;
        do
            @(posedge clk);
        while (pending_verdicts.size() != 0);
    endtask

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && done)
        begin
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, got order=%0d truncated=%0b",
                         $time, order, truncated);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (order !== want.ord)
                begin
                    errors++;
                    $display("%0t: order mismatch: expected %0d, got %0d",
                             $time, want.ord, order);
                end
                if (truncated !== want.trunc)
                begin
                    errors++;
                    $display("%0t: truncated mismatch: expected %0b, got %0b",
                             $time, want.trunc, truncated);
                end
            end
        end
    end

    initial
    begin
        int lhs_n;
        int rhs_n;
        int ai;
        int bi;
        int pair;
        int idx;
        bit take_lhs;

        rst_n     = 1'b0;
        start     = 1'b0;
        opcode    = OP_APPEND_FIRST;
        char_byte = 8'h00;
        lhs_len   = 0;
        rhs_len   = 0;
        dropped   = 1'b0;

        script = '{
            '{OP_COMPARE,       8'h00, 1'b1, ORD_EQ, 1'b0},  // two empty strings
            '{OP_APPEND_FIRST,  8'h31, 1'b0, ORD_EQ, 1'b0},
            '{OP_COMPARE,       8'hFF, 1'b1, ORD_GT, 1'b0},  // empty second
            '{OP_APPEND_SECOND, 8'h00, 1'b0, ORD_EQ, 1'b0},
            '{OP_COMPARE,       8'h00, 1'b1, ORD_LT, 1'b0},  // empty first
            '{OP_APPEND_FIRST,  8'h39, 1'b0, ORD_EQ, 1'b0},
            '{OP_APPEND_SECOND, 8'h31, 1'b0, ORD_EQ, 1'b0},
            '{OP_APPEND_SECOND, 8'h30, 1'b0, ORD_EQ, 1'b0},
            '{OP_COMPARE,       8'h00, 1'b1, ORD_LT, 1'b0},  // 9 < 10
            '{OP_APPEND_FIRST,  8'h30, 1'b0, ORD_EQ, 1'b0},
            '{OP_APPEND_FIRST,  8'h30, 1'b0, ORD_EQ, 1'b0},
            '{OP_APPEND_FIRST,  8'h37, 1'b0, ORD_EQ, 1'b0},
            '{OP_APPEND_SECOND, 8'h37, 1'b0, ORD_EQ, 1'b0},
            '{OP_COMPARE,       8'h00, 1'b0, ORD_EQ, 1'b0},  // leading zeros
            '{OP_APPEND_FIRST,  8'h31, 1'b0, ORD_EQ, 1'b0},
            '{OP_APPEND_SECOND, 8'h61, 1'b0, ORD_EQ, 1'b0},
            '{OP_COMPARE,       8'h00, 1'b1, ORD_GT, 1'b0},  // digit run vs text
            '{OP_APPEND_FIRST,  8'hFF, 1'b0, ORD_EQ, 1'b0},
            '{OP_APPEND_SECOND, 8'h35, 1'b0, ORD_EQ, 1'b0},
            '{OP_COMPARE,       8'h00, 1'b1, ORD_LT, 1'b0},  // text run vs digit
            '{OP_UNUSED,        8'hAA, 1'b0, ORD_EQ, 1'b0},
            '{OP_APPEND_FIRST,  8'hFF, 1'b0, ORD_EQ, 1'b0},
            '{OP_APPEND_SECOND, 8'hFE, 1'b0, ORD_EQ, 1'b0},
            '{OP_COMPARE,       8'h00, 1'b1, ORD_GT, 1'b0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[k])
            send_cmd(script[k].op, script[k].ch, script[k].typed,
                     script[k].ord, script[k].trunc);
        drain();

        pair = 0;
        while (n_sent < ITEM_TARGET)
        begin
            calm = (n_sent >= 400 && n_sent < 600);

            // A few pairs run past capacity; most stay short.
            if (pair == 3)
            begin
                lhs_n = 66;
                rhs_n = $urandom_range(0, 8);
            end
            else if (pair == 28)
            begin
                lhs_n = $urandom_range(58, 64);
                rhs_n = 67;
            end
            else if (pair % 25 == 11)
            begin
                lhs_n = $urandom_range(58, 72);
                rhs_n = $urandom_range(58, 72);
            end
            else
            begin
                lhs_n = $urandom_range(0, 8);
                rhs_n = $urandom_range(0, 8);
            end

            make_text(lhs_n);
            lhs_src = scratch;
            rhs_src = scratch;
            case ($urandom_range(0, 6))
                0, 1:
                begin
                    make_text(rhs_n);
                    rhs_src = scratch;
                end
                2:
                    if (rhs_src.size() > 0)
                    begin
                        idx = $urandom_range(0, rhs_src.size() - 1);
                        rhs_src[idx] = pick_char(1'($urandom_range(0, 1)));
                    end
                3:
                    repeat ($urandom_range(1, 3))
                        if (rhs_src.size() > 0)
                            void'(rhs_src.pop_back());
                4:
                    repeat ($urandom_range(1, 3))
                        rhs_src.push_back(pick_char(1'($urandom_range(0, 1))));
                5:
                    rhs_src.insert($urandom_range(0, rhs_src.size()), CH_ZERO);
                default: ;
            endcase

            // Interleave the appends of both strings at random.
            ai = 0;
            bi = 0;
            while (ai < lhs_src.size() || bi < rhs_src.size())
            begin
                take_lhs = (bi >= rhs_src.size()) ||
                           (ai < lhs_src.size() && $urandom_range(0, 1));
                if (take_lhs)
                    send_cmd(OP_APPEND_FIRST, lhs_src[ai++]);
                else
                    send_cmd(OP_APPEND_SECOND, rhs_src[bi++]);
                if ($urandom_range(0, 29) == 0)
                    send_cmd(OP_UNUSED, 8'($urandom_range(0, 255)));
            end

            // Now and then leave the pair open so the next one piles on.
            if ($urandom_range(0, 19) != 0)
                send_cmd(OP_COMPARE, 8'($urandom_range(0, 255)));

            pair++;
            if (pair % 40 == 0)
                drain();
        end
        send_cmd(OP_COMPARE, 8'($urandom_range(0, 255)));

        drain();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

/* sim.f */
sv/vsc_pkg.sv
sv/vsc_front.sv
sv/vsc_back.sv
sv/version_string_compare_top.sv
test/tb.sv
